@@ src/stib_pkg.sv @@
// ----------------------------------------------------------------------------
// String to integer parser: shared package
// Character codes, register indexes, phase encoding and the command and
// result records passed between the parser stages.
// ----------------------------------------------------------------------------
package stib_pkg;

    localparam int CH_W        = 8;
    localparam int ALPHA_SLOTS = 16;
    localparam int MAX_DIGITS  = 16;
    localparam int POS_W       = 4;
    localparam int RADIX_W     = 5;
    localparam int LEN_W       = 5;
    localparam int OUT_W       = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd2;

    // Character codes
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;

    localparam logic [LEN_W-1:0] MIN_ALPHA_LEN = 5'd2;

    typedef enum logic [1:0] {
        PH_BLANK  = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGIT  = 2'd2,
        PH_FROZEN = 2'd3
    } t_phase;

    // One classified character on its way to the accumulator
    typedef struct packed {
        logic               is_blank;
        logic               is_plus;
        logic               is_minus;
        logic               is_digit;
        logic [POS_W-1:0]   pos;
        logic [RADIX_W-1:0] mul;
        logic               last;
        logic               invalid;
    } t_cmd;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             alphabet_invalid;
    } t_res;

endpackage

@@ src/stib_fifo.sv @@
// ----------------------------------------------------------------------------
// String to integer parser: small synchronous queue
// Flop based first-in first-out store with full and empty flags.
// ----------------------------------------------------------------------------
module stib_fifo #(
    parameter int WIDTH      = 16,
    parameter int DEPTH_LOG2 = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [WIDTH-1:0]      r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wr_ptr;
    logic [DEPTH_LOG2-1:0] r_rd_ptr;
    logic [DEPTH_LOG2:0]   r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == (DEPTH_LOG2+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (DEPTH_LOG2+1)'(DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

@@ src/stib_front.sv @@
// ----------------------------------------------------------------------------
// String to integer parser: front end
// Holds the configuration registers and classifies each incoming
// character against the digit alphabet: blank, sign, digit position.
// ----------------------------------------------------------------------------
module stib_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [stib_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [stib_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [stib_pkg::CH_W-1:0]          i_ch,
    input  logic                               i_is_last,
    output stib_pkg::t_cmd                     o_cmd
);

    logic [stib_pkg::CFG_DATA_W-1:0] r_alpha_low;
    logic [stib_pkg::CFG_DATA_W-1:0] r_alpha_high;
    logic [stib_pkg::RADIX_W-1:0]    r_radix;

    logic [2*stib_pkg::CFG_DATA_W-1:0] alpha_flat;
    logic [stib_pkg::CH_W-1:0]         chars [stib_pkg::ALPHA_SLOTS];
    logic [stib_pkg::ALPHA_SLOTS-1:0]  slot_used;
    logic [stib_pkg::LEN_W-1:0]        alpha_len;
    logic                              run;
    logic                              bad;
    logic                              hit;
    logic [stib_pkg::POS_W-1:0]        pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_low  <= '0;
            r_alpha_high <= '0;
            r_radix      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                stib_pkg::CFG_ALPHA_LOW:  r_alpha_low  <= i_cfg_data;
                stib_pkg::CFG_ALPHA_HIGH: r_alpha_high <= i_cfg_data;
                stib_pkg::CFG_RADIX:      r_radix      <= i_cfg_data[stib_pkg::RADIX_W-1:0];
                default: ;
            endcase
        end
    end

    assign alpha_flat = {r_alpha_high, r_alpha_low};

    always_comb begin
        for (int i = 0; i < stib_pkg::ALPHA_SLOTS; i++) begin
            chars[i] = alpha_flat[i*stib_pkg::CH_W +: stib_pkg::CH_W];
        end
    end

    // The alphabet runs up to the first zero byte
    always_comb begin
        run = 1'b1;
        for (int i = 0; i < stib_pkg::ALPHA_SLOTS; i++) begin
            run = run && (chars[i] != stib_pkg::CH_NUL) && (i < stib_pkg::MAX_DIGITS);
            slot_used[i] = run;
        end
    end

    assign alpha_len = stib_pkg::LEN_W'($countones(slot_used));

    // Signs or a repeated character anywhere in the alphabet spoil it
    always_comb begin
        bad = 1'b0;
        for (int i = 0; i < stib_pkg::ALPHA_SLOTS; i++) begin
            if (slot_used[i] &&
                (chars[i] == stib_pkg::CH_PLUS || chars[i] == stib_pkg::CH_MINUS)) begin
                bad = 1'b1;
            end
            for (int j = i + 1; j < stib_pkg::ALPHA_SLOTS; j++) begin
                if (slot_used[j] && chars[j] == chars[i]) begin
                    bad = 1'b1;
                end
            end
        end
    end

    // First matching slot wins
    always_comb begin
        hit = 1'b0;
        pos = '0;
        for (int i = stib_pkg::ALPHA_SLOTS - 1; i >= 0; i--) begin
            if (slot_used[i] && chars[i] == i_ch) begin
                hit = 1'b1;
                pos = stib_pkg::POS_W'(i);
            end
        end
    end

    always_comb begin
        o_cmd.is_blank = (i_ch == stib_pkg::CH_SPACE) ||
                         (i_ch >= stib_pkg::CH_TAB && i_ch <= stib_pkg::CH_CR);
        o_cmd.is_plus  = (i_ch == stib_pkg::CH_PLUS);
        o_cmd.is_minus = (i_ch == stib_pkg::CH_MINUS);
        o_cmd.is_digit = hit;
        o_cmd.pos      = pos;
        o_cmd.mul      = (r_radix != '0) ? r_radix : alpha_len[stib_pkg::RADIX_W-1:0];
        o_cmd.last     = i_is_last;
        o_cmd.invalid  = bad || (alpha_len < stib_pkg::MIN_ALPHA_LEN);
    end

endmodule

@@ src/stib_back.sv @@
// ----------------------------------------------------------------------------
// String to integer parser: back end
// Runs the blank / sign / digit phase machine over classified characters,
// accumulates the value and forms the result on the last character.
// ----------------------------------------------------------------------------
module stib_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stib_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    input  logic           i_res_full,
    output logic           o_res_push,
    output stib_pkg::t_res o_res
);

    stib_pkg::t_phase r_phase;
    stib_pkg::t_phase n_phase;
    logic                  r_neg;
    logic                  n_neg;
    logic [VALUE_BITS-1:0] r_acc;
    logic [VALUE_BITS-1:0] n_acc;

    stib_pkg::t_phase      step_phase;
    logic                  step_neg;
    logic [VALUE_BITS-1:0] step_acc;
    logic [63:0]           acc_ext;
    logic [63:0]           signed_val;

    // Hold a last character back only while the result queue is full
    assign o_cmd_pop  = i_cmd_valid && (!i_cmd.last || !i_res_full);
    assign o_res_push = o_cmd_pop && i_cmd.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= stib_pkg::PH_BLANK;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg <= 1'b0;
            r_acc <= '0;
        end else begin
            r_neg <= n_neg;
            r_acc <= n_acc;
        end
    end

    always_comb begin
        step_phase = r_phase;
        step_neg   = r_neg;
        step_acc   = r_acc;
        if (step_phase == stib_pkg::PH_BLANK && !i_cmd.is_blank) begin
            step_phase = stib_pkg::PH_SIGN;
        end
        if (step_phase == stib_pkg::PH_SIGN) begin
            if (i_cmd.is_minus) begin
                step_neg = ~step_neg;
            end else if (!i_cmd.is_plus) begin
                step_phase = stib_pkg::PH_DIGIT;
            end
        end
        if (step_phase == stib_pkg::PH_DIGIT) begin
            if (i_cmd.is_digit) begin
                step_acc = VALUE_BITS'(r_acc * VALUE_BITS'(i_cmd.mul))
                         + VALUE_BITS'(i_cmd.pos);
            end else begin
                step_phase = stib_pkg::PH_FROZEN;
            end
        end

        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        if (o_cmd_pop) begin
            if (i_cmd.last) begin
                n_phase = stib_pkg::PH_BLANK;
                n_neg   = 1'b0;
                n_acc   = '0;
            end else begin
                n_phase = step_phase;
                n_neg   = step_neg;
                n_acc   = step_acc;
            end
        end
    end

    assign acc_ext    = 64'(step_acc);
    assign signed_val = step_neg ? (64'd0 - acc_ext) : acc_ext;

    always_comb begin
        o_res.alphabet_invalid = i_cmd.invalid;
        o_res.value            = i_cmd.invalid ? '0 : signed_val[stib_pkg::OUT_W-1:0];
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result written into a full queue");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && i_cmd.last) |=>
            (r_phase == stib_pkg::PH_BLANK && !r_neg && r_acc == '0))
        else $error("parser not back to blank skipping after a string end");

    a_frozen_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && !i_cmd.last && r_phase == stib_pkg::PH_FROZEN) |=>
            ($stable(r_acc) && r_phase == stib_pkg::PH_FROZEN))
        else $error("accumulator moved after the value froze");

endmodule

@@ src/string_to_int_any_base_core.sv @@
// ----------------------------------------------------------------------------
// String to integer parser with configurable digit alphabet
// Top level: front classifier, command queue, accumulator back end and
// result queue.
// ----------------------------------------------------------------------------
// Takes one character per clock cycle without gaps: a character is
// transferred whenever push is high and full is low, and the back end
// drains one queued character every cycle unless it holds a last character back
// while the result queue is full. A string's result is written to the result
// queue when its last character leaves the command queue; the result queue
// shows it as soon as it is written, and it stays there until popped. The
// alphabet compare and the accumulator multiply-add are combinational; only
// a full result queue holding back a last character slows the input side.
// The alphabet and radix may be rewritten between characters of a string;
// each character is classified with the settings in force when transferred.
module string_to_int_any_base_core #(
    parameter int VALUE_BITS     = 32,
    parameter int CMD_DEPTH_LOG2 = 2,
    parameter int RES_DEPTH_LOG2 = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [stib_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [stib_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [stib_pkg::CH_W-1:0]       i_ch,
    input  logic                            i_is_last,
    output logic                            empty,
    input  logic                            pop,
    output logic signed [stib_pkg::OUT_W-1:0] o_value,
    output logic                            o_alphabet_invalid
);

    stib_pkg::t_cmd front_cmd;
    stib_pkg::t_cmd queued_cmd;
    logic           cmd_empty;
    logic           cmd_pop;
    stib_pkg::t_res back_res;
    stib_pkg::t_res out_res;
    logic           res_full;
    logic           res_push;

    stib_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ch       (i_ch),
        .i_is_last  (i_is_last),
        .o_cmd      (front_cmd)
    );

    stib_fifo #(
        .WIDTH      ($bits(stib_pkg::t_cmd)),
        .DEPTH_LOG2 (CMD_DEPTH_LOG2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (cmd_pop),
        .o_data  (queued_cmd),
        .o_full  (full),
        .o_empty (cmd_empty)
    );

    stib_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queued_cmd),
        .i_cmd_valid (!cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    stib_fifo #(
        .WIDTH      ($bits(stib_pkg::t_res)),
        .DEPTH_LOG2 (RES_DEPTH_LOG2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign o_value            = $signed(out_res.value);
    assign o_alphabet_invalid = out_res.alphabet_invalid;

endmodule
